// ===== rtl/core/mebs_pkg.sv =====
// Shared types and constants for the MIDI event byte serializer.
package mebs_pkg;

   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_TRACK   = 3'd1;
   localparam logic [2:0] KIND_TEMPO   = 3'd2;
   localparam logic [2:0] KIND_PROGRAM = 3'd3;
   localparam logic [2:0] KIND_NOTE_ON = 3'd4;
   localparam logic [2:0] KIND_NOTE_OFF = 3'd5;
   localparam logic [2:0] KIND_EOT     = 3'd6;

   localparam logic [1:0] REG_FORMAT   = 2'd0;
   localparam logic [1:0] REG_TRACKS   = 2'd1;
   localparam logic [1:0] REG_DIVISION = 2'd2;

   localparam int unsigned CSR_ADDR_W = 4;

   localparam logic [1:0]  FORMAT_RESET   = 2'd1;
   localparam logic [15:0] TRACKS_RESET   = 16'd1;
   localparam logic [15:0] DIVISION_RESET = 16'd480;

   typedef struct packed {
      logic       load;
      logic       emit;
      logic       last;
      logic       clear_count;
      logic [3:0] byte_idx;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] len;
   } status_type;

endpackage

// ===== rtl/core/mebs_req_if.sv =====
// Input event channel.
interface mebs_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [27:0] delta_time;
   logic [3:0]  channel;
   logic [6:0]  note;
   logic [6:0]  velocity;
   logic [6:0]  instrument;
   logic [23:0] tempo_value;

   modport source (output valid, kind, delta_time, channel, note, velocity, instrument,
                   tempo_value, input ready);
   modport sink (input valid, kind, delta_time, channel, note, velocity, instrument,
                 tempo_value, output ready);
endinterface

// ===== rtl/core/mebs_rsp_if.sv =====
// Output byte channel.
interface mebs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        last;
   logic        error;
   logic [31:0] track_length;

   modport source (output valid, out_byte, last, error, track_length, input ready);
   modport sink (input valid, out_byte, last, error, track_length, output ready);
endinterface

// ===== rtl/core/mebs_ctrl.sv =====
// Sequencer: accepts events and steps through their bytes.
module mebs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mebs_pkg::status_type status,
   output mebs_pkg::cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   logic       state_ff, state_in;
   logic [3:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.byte_idx = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (status.len == 4'd0) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               cmd.emit = 1'b1;
               cmd.last = (idx_ff == status.len - 4'd1);
               idx_in   = idx_ff + 4'd1;
               if (cmd.last) begin
                  state_in = ST_IDLE;
                  cmd.clear_count = (status.kind == mebs_pkg::KIND_EOT);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/mebs_dpath.sv =====
// Datapath: event registers, config registers, byte select, track counter, output register.
module mebs_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  mebs_pkg::cmd_type                   cmd,
   output mebs_pkg::status_type                status,
   input  logic [2:0]                          kind,
   input  logic [27:0]                         delta_time,
   input  logic [3:0]                          channel,
   input  logic [6:0]                          note,
   input  logic [6:0]                          velocity,
   input  logic [6:0]                          instrument,
   input  logic [23:0]                         tempo_value,
   input  logic                                csr_wr,
   input  logic [mebs_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [31:0]                         csr_wdata,
   output logic [31:0]                         csr_rdata,
   output logic [7:0]                          out_byte,
   output logic                                last,
   output logic                                error,
   output logic [31:0]                         track_length
);

   logic [1:0]  format_ff;
   logic [15:0] tracks_ff;
   logic [15:0] division_ff;

   logic [2:0]  kind_ff;
   logic [27:0] delta_ff;
   logic [3:0]  chan_ff;
   logic [6:0]  note_ff, vel_ff, inst_ff;
   logic [23:0] tempo_ff;
   logic [3:0]  vlq_len_ff, len_ff;
   logic        err_ff;
   logic [31:0] count_ff, count_in;

   logic [7:0]  byte_out_ff;
   logic        last_ff, error_ff;
   logic [31:0] tlen_ff;

   logic [3:0]  vlq_len_in, len_in;
   logic        err_in;
   logic [1:0]  reg_sel;
   logic [3:0]  pidx;
   logic [1:0]  grp;
   logic [6:0]  grp_bits;
   logic [7:0]  sel_byte;
   logic [3:0]  idx;

   assign reg_sel = csr_addr[3:2];
   assign idx     = cmd.byte_idx;

   always_comb begin
      case (reg_sel)
         mebs_pkg::REG_FORMAT:   csr_rdata = {30'd0, format_ff};
         mebs_pkg::REG_TRACKS:   csr_rdata = {16'd0, tracks_ff};
         mebs_pkg::REG_DIVISION: csr_rdata = {16'd0, division_ff};
         default:                csr_rdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff   <= mebs_pkg::FORMAT_RESET;
         tracks_ff   <= mebs_pkg::TRACKS_RESET;
         division_ff <= mebs_pkg::DIVISION_RESET;
      end else if (csr_wr) begin
         case (reg_sel)
            mebs_pkg::REG_FORMAT:   format_ff   <= csr_wdata[1:0];
            mebs_pkg::REG_TRACKS:   tracks_ff   <= csr_wdata[15:0];
            mebs_pkg::REG_DIVISION: division_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // event length at load time
   always_comb begin
      if (delta_time[27:21] != '0)      vlq_len_in = 4'd4;
      else if (delta_time[20:14] != '0) vlq_len_in = 4'd3;
      else if (delta_time[13:7] != '0)  vlq_len_in = 4'd2;
      else                              vlq_len_in = 4'd1;
      err_in = (kind == mebs_pkg::KIND_HEADER) && (format_ff == 2'd0) && (tracks_ff > 16'd1);
      case (kind)
         mebs_pkg::KIND_HEADER:   len_in = err_in ? 4'd1 : 4'd14;
         mebs_pkg::KIND_TRACK:    len_in = 4'd8;
         mebs_pkg::KIND_TEMPO:    len_in = vlq_len_in + 4'd6;
         mebs_pkg::KIND_PROGRAM:  len_in = vlq_len_in + 4'd2;
         mebs_pkg::KIND_NOTE_ON,
         mebs_pkg::KIND_NOTE_OFF,
         mebs_pkg::KIND_EOT:      len_in = vlq_len_in + 4'd3;
         default:                 len_in = 4'd0;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.load) begin
         case (kind) inside
            mebs_pkg::KIND_TRACK: count_in = '0;
            [mebs_pkg::KIND_TEMPO:mebs_pkg::KIND_EOT]: count_in = count_ff + {28'd0, len_in};
            default: ;
         endcase
      end else if (cmd.clear_count) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         kind_ff  <= mebs_pkg::KIND_HEADER;
         len_ff   <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.load) begin
            kind_ff <= kind;
            len_ff  <= len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         delta_ff   <= delta_time;
         chan_ff    <= channel;
         note_ff    <= note;
         vel_ff     <= velocity;
         inst_ff    <= instrument;
         tempo_ff   <= tempo_value;
         vlq_len_ff <= vlq_len_in;
         err_ff     <= err_in;
      end
   end

   assign status.kind = kind_ff;
   assign status.len  = len_ff;

   // byte select
   always_comb begin
      pidx = idx - vlq_len_ff;
      grp  = 2'(vlq_len_ff - 4'd1 - idx);
      case (grp)
         2'd0:    grp_bits = delta_ff[6:0];
         2'd1:    grp_bits = delta_ff[13:7];
         2'd2:    grp_bits = delta_ff[20:14];
         default: grp_bits = delta_ff[27:21];
      endcase
      sel_byte = 8'h00;
      case (kind_ff)
         mebs_pkg::KIND_HEADER: begin
            if (!err_ff) begin
               case (idx)
                  4'd0:    sel_byte = 8'h4D;
                  4'd1:    sel_byte = 8'h54;
                  4'd2:    sel_byte = 8'h68;
                  4'd3:    sel_byte = 8'h64;
                  4'd7:    sel_byte = 8'h06;
                  4'd9:    sel_byte = {6'd0, format_ff};
                  4'd10:   sel_byte = tracks_ff[15:8];
                  4'd11:   sel_byte = tracks_ff[7:0];
                  4'd12:   sel_byte = division_ff[15:8];
                  4'd13:   sel_byte = division_ff[7:0];
                  default: sel_byte = 8'h00;
               endcase
            end
         end
         mebs_pkg::KIND_TRACK: begin
            case (idx)
               4'd0:    sel_byte = 8'h4D;
               4'd1:    sel_byte = 8'h54;
               4'd2:    sel_byte = 8'h72;
               4'd3:    sel_byte = 8'h6B;
               default: sel_byte = 8'h00;
            endcase
         end
         default: begin
            if (idx < vlq_len_ff) begin
               sel_byte = {(idx < vlq_len_ff - 4'd1), grp_bits};
            end else begin
               case (kind_ff)
                  mebs_pkg::KIND_TEMPO: begin
                     case (pidx)
                        4'd0:    sel_byte = 8'hFF;
                        4'd1:    sel_byte = 8'h51;
                        4'd2:    sel_byte = 8'h03;
                        4'd3:    sel_byte = tempo_ff[23:16];
                        4'd4:    sel_byte = tempo_ff[15:8];
                        default: sel_byte = tempo_ff[7:0];
                     endcase
                  end
                  mebs_pkg::KIND_PROGRAM: begin
                     sel_byte = (pidx == 4'd0) ? {4'hC, chan_ff} : {1'b0, inst_ff};
                  end
                  mebs_pkg::KIND_NOTE_ON,
                  mebs_pkg::KIND_NOTE_OFF: begin
                     case (pidx)
                        4'd0: begin
                           sel_byte = (kind_ff == mebs_pkg::KIND_NOTE_ON) ?
                                      {4'h9, chan_ff} : {4'h8, chan_ff};
                        end
                        4'd1:    sel_byte = {1'b0, note_ff};
                        default: sel_byte = {1'b0, vel_ff};
                     endcase
                  end
                  default: begin
                     case (pidx)
                        4'd0:    sel_byte = 8'hFF;
                        4'd1:    sel_byte = 8'h2F;
                        default: sel_byte = 8'h00;
                     endcase
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         byte_out_ff <= sel_byte;
         last_ff     <= cmd.last;
         error_ff    <= err_ff;
         tlen_ff     <= (cmd.last && kind_ff == mebs_pkg::KIND_EOT) ? count_ff : 32'd0;
      end
   end

   assign out_byte     = byte_out_ff;
   assign last         = last_ff;
   assign error        = error_ff;
   assign track_length = tlen_ff;

endmodule

// ===== rtl/core/midi_event_byte_serializer.sv =====
// Top level of the MIDI event byte serializer.
// The event is latched at transfer; its first byte then reaches rsp_ch through the output register.
// Throughput: the byte sequencer emits one byte per cycle while rsp_ch is not stalled
// and accepts a new event only after the last byte of the current one.
// Reset: synchronous active high; clears the sequencer, track count and config
// registers (format 1, tracks 1, division 480).
module midi_event_byte_serializer (
   input  logic                             clock,
   input  logic                             reset,
   mebs_req_if.sink                         req_ch,
   mebs_rsp_if.source                       rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mebs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   mebs_pkg::cmd_type    cmd;
   mebs_pkg::status_type status;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   mebs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mebs_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .kind         (req_ch.kind),
      .delta_time   (req_ch.delta_time),
      .channel      (req_ch.channel),
      .note         (req_ch.note),
      .velocity     (req_ch.velocity),
      .instrument   (req_ch.instrument),
      .tempo_value  (req_ch.tempo_value),
      .csr_wr       (csr_wr),
      .csr_addr     (csr_paddr),
      .csr_wdata    (csr_pwdata),
      .csr_rdata    (csr_prdata),
      .out_byte     (rsp_ch.out_byte),
      .last         (rsp_ch.last),
      .error        (rsp_ch.error),
      .track_length (rsp_ch.track_length)
   );

endmodule

// ===== rtl/core/mebs_checker.sv =====
// Port-level checker for the MIDI event byte serializer, bound to the top level.
module mebs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  out_byte,
   input logic        last,
   input logic        error,
   input logic [31:0] track_length,
   input logic        csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(last)
                                  && $stable(error) && $stable(track_length))
      else $error("stalled transfer changed");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && error |-> last && out_byte == 8'h00 && track_length == 32'd0)
      else $error("malformed error transfer");

   a_length_on_eot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && track_length != 32'd0 |-> last && out_byte == 8'h00 && !error)
      else $error("track length outside end-of-track byte");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

endmodule

bind midi_event_byte_serializer mebs_checker u_mebs_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .out_byte     (rsp_ch.out_byte),
   .last         (rsp_ch.last),
   .error        (rsp_ch.error),
   .track_length (rsp_ch.track_length),
   .csr_pready   (csr_pready)
);
